// ===== design/scancode_to_ascii_fifo_defines.svh =====
// assertion macros shared by the scancode converter checkers
// expects clk_i and rst_ni in the scope of each use
`ifndef SCANCODE_TO_ASCII_FIFO_DEFINES_SVH
`define SCANCODE_TO_ASCII_FIFO_DEFINES_SVH

// same-cycle implication, checked out of reset
`define S2A_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define S2A_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/s2a_pkg.sv =====
// types, codes and the set-1 key table for the scancode converter
// no dependencies
`timescale 1ns / 1ps

package s2a_pkg;

  typedef logic [6:0] char_t;
  typedef logic [7:0] scan_t;

  localparam logic  OpScan     = 1'b0;
  localparam logic  OpRead     = 1'b1;
  localparam scan_t PrefixExt  = 8'hE0;
  localparam int    ReleaseBit = 7;

  // us layout, make codes 0x00 to 0x7f, zero where no character
  function automatic char_t key_map(input logic [6:0] code);
    char_t ch;
    case (code)
      7'h01: ch = 7'h1B;  // escape
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h0C: ch = 7'h2D;
      7'h0D: ch = 7'h3D;
      7'h0E: ch = 7'h08;  // backspace
      7'h0F: ch = 7'h09;  // tab
      7'h10: ch = 7'h71;
      7'h11: ch = 7'h77;
      7'h12: ch = 7'h65;
      7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;
      7'h16: ch = 7'h75;
      7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F;
      7'h19: ch = 7'h70;
      7'h1A: ch = 7'h5B;
      7'h1B: ch = 7'h5D;
      7'h1C: ch = 7'h0A;  // enter
      7'h1E: ch = 7'h61;
      7'h1F: ch = 7'h73;
      7'h20: ch = 7'h64;
      7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;
      7'h23: ch = 7'h68;
      7'h24: ch = 7'h6A;
      7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;
      7'h27: ch = 7'h3B;
      7'h28: ch = 7'h27;
      7'h29: ch = 7'h60;
      7'h2B: ch = 7'h5C;
      7'h2C: ch = 7'h7A;
      7'h2D: ch = 7'h78;
      7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;
      7'h31: ch = 7'h6E;
      7'h32: ch = 7'h6D;
      7'h33: ch = 7'h2C;
      7'h34: ch = 7'h2E;
      7'h35: ch = 7'h2F;
      7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/s2a_intf.sv =====
// valid/ready channels of the scancode converter: input, result and config
// depends on s2a_pkg
`timescale 1ns / 1ps

interface s2a_in_if;
  logic            valid;
  logic            ready;
  logic            op;
  s2a_pkg::scan_t  scan_byte;

  modport source (output valid, op, scan_byte, input ready);
  modport sink   (input valid, op, scan_byte, output ready);
endinterface

interface s2a_out_if;
  logic            valid;
  logic            ready;
  s2a_pkg::char_t  ascii_char;
  logic            char_accepted;
  logic            buffer_empty;

  modport source (output valid, ascii_char, char_accepted, buffer_empty, input ready);
  modport sink   (input valid, ascii_char, char_accepted, buffer_empty, output ready);
endinterface

interface s2a_cfg_if;
  logic valid;
  logic ready;
  logic game_mode;

  modport source (output valid, game_mode, input ready);
  modport sink   (input valid, game_mode, output ready);
endinterface

// ===== design/scancode_to_ascii_fifo.sv =====
// an accepted item passes through the holding stage, then the result stage, to out_o
// throughput: one item per cycle while out_o is not stalled; one table lookup,
//   at most one write and at most one registered read of the character ring per item
// a result stage and a holding stage let one more item in while out_o stalls
// reset clears pointers, prefix flag, mode and valids; ring contents undefined
`timescale 1ns / 1ps

module scancode_to_ascii_fifo #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  s2a_in_if.sink         in_i,
  s2a_cfg_if.sink        cfg_i,
  s2a_out_if.source      out_o
);
  import s2a_pkg::*;

  localparam int              AW      = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [AW-1:0]   LastIdx = AW'(BUFFER_DEPTH - 1);

  char_t           mem [BUFFER_DEPTH];
  char_t           rdata_q;

  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic            ext_q, game_mode_q;

  // holding stage
  logic            s1_v_q, s1_rd_q, s1_acc_q, s1_empty_q;
  char_t           s1_char_q;

  // result stage
  logic            o_v_q, o_acc_q, o_empty_q;
  char_t           o_char_q;

  logic            accept, s1_move;
  logic            is_rd, prefix, release_code, make_code;
  logic            push, pop, ring_empty;
  char_t           mapped;

  assign s1_move = s1_v_q && (!o_v_q || out_o.ready);
  assign in_i.ready = !s1_v_q || s1_move;
  assign accept  = in_i.valid && in_i.ready;

  assign is_rd        = (in_i.op == OpRead);
  assign prefix       = !is_rd && (in_i.scan_byte == PrefixExt);
  assign release_code = !is_rd && in_i.scan_byte[ReleaseBit] && !prefix;
  assign make_code    = !is_rd && !in_i.scan_byte[ReleaseBit];

  assign mapped     = key_map(in_i.scan_byte[6:0]);
  assign ring_empty = (rd_ptr_q == wr_ptr_q);
  assign push       = make_code && !game_mode_q && !ext_q && (mapped != '0);
  assign pop        = is_rd && !ring_empty;

  assign cfg_i.ready = 1'b1;

  // character ring, no reset
  always_ff @(posedge clk_i) begin
    if (accept && push) begin
      mem[wr_ptr_q] <= mapped;
    end
    if (accept && pop) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      ext_q       <= 1'b0;
      game_mode_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        game_mode_q <= cfg_i.game_mode;
      end
      if (accept) begin
        if (push) begin
          wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
        end
        if (pop) begin
          rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);
        end
        // a read leaves the prefix flag alone
        if (prefix) begin
          ext_q <= 1'b1;
        end else if (release_code || make_code) begin
          ext_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        o_v_q <= 1'b1;
      end else if (out_o.ready) begin
        o_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q    <= pop;
      s1_acc_q   <= push;
      s1_empty_q <= is_rd && ring_empty;
      s1_char_q  <= push ? mapped : '0;
    end
    if (s1_move) begin
      o_char_q  <= s1_rd_q ? rdata_q : s1_char_q;
      o_acc_q   <= s1_acc_q;
      o_empty_q <= s1_empty_q;
    end
  end

  assign out_o.valid         = o_v_q;
  assign out_o.ascii_char    = o_char_q;
  assign out_o.char_accepted = o_acc_q;
  assign out_o.buffer_empty  = o_empty_q;

endmodule

// ===== design/s2a_checker.sv =====
// port-level checks for scancode_to_ascii_fifo, attached by bind
// depends on s2a_pkg and scancode_to_ascii_fifo_defines.svh
`timescale 1ns / 1ps
`include "scancode_to_ascii_fifo_defines.svh"

module s2a_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input s2a_pkg::char_t ascii_char_i,
  input logic           char_accepted_i,
  input logic           buffer_empty_i
);

  // a result only appears after an item came in and passed the holding stage
  `S2A_ASSERT_SAME(a_rise_follows_accept, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result without a preceding item")

  // input only backs off when a result is waiting and stalled
  `S2A_ASSERT_SAME(a_ready_only_on_stall, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without output back-pressure")

  // a stalled result holds
  `S2A_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(ascii_char_i) && $stable(char_accepted_i) && $stable(buffer_empty_i), "stalled result changed")

endmodule

bind scancode_to_ascii_fifo s2a_checker u_s2a_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .ascii_char_i    (out_o.ascii_char),
  .char_accepted_i (out_o.char_accepted),
  .buffer_empty_i  (out_o.buffer_empty)
);

// ===== bench/tb_scancode_to_ascii_fifo.sv =====
// self-checking bench for scancode_to_ascii_fifo: keyboard bytes and reads in,
// characters out, checked against an in-bench model of the table and ring
// depends on s2a_pkg, s2a_intf.sv and the block itself
`timescale 1ns / 1ps

module tb_scancode_to_ascii_fifo;
  import s2a_pkg::*;

  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LATENCY = 2;

  // set-1 make codes 0x00..0x39, '~' where a code gives no character
  localparam bit [8*58-1:0] US_KEYS =
    "~\0331234567890-=\010\tqwertyuiop[]\n~asdfghjkl;'`~\\zxcvbnm,./~*~ ";

  typedef struct packed {
    logic  op;
    scan_t sb;
  } key_item_t;

  typedef struct packed {
    char_t ch;
    logic  acc;
    logic  empty;
  } result_t;

  logic clk_i;
  logic rst_ni;

  s2a_in_if  in_if ();
  s2a_cfg_if cfg_if ();
  s2a_out_if out_if ();

  scancode_to_ascii_fifo #(
    .BUFFER_DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .cfg_i (cfg_if.sink),
    .out_o (out_if.source)
  );

  // model state
  logic  game_on;
  logic  ext_armed;
  char_t ring [DEPTH];
  int    wr_ptr;
  int    rd_ptr;

  key_item_t key_queue [$];
  result_t   awaited_results [$];
  key_item_t next_key;
  result_t   head_result;
  logic      holding;
  int        gap_left;
  int        burst_left;
  int        cyc;
  int        n_errors;
  int        n_items;
  int        n_buffered;
  int        n_readback;
  int        n_empty;
  int        n_wraps;
  int        n_mode_writes;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic char_t us_char(input logic [6:0] code);
    logic [7:0] c;
    if (code > 7'd57) return '0;
    c = US_KEYS[8*(57-code) +: 8];
    return (c == "~") ? char_t'(0) : c[6:0];
  endfunction

  function automatic result_t decode_key(input key_item_t it);
    result_t r;
    char_t   ch;
    r = '0;
    n_items++;
    if (it.op == OpRead) begin
      if (rd_ptr == wr_ptr) begin
        r.empty = 1'b1;
        n_empty++;
      end else begin
        r.ch = ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % DEPTH;
        n_readback++;
      end
    end else if (it.sb == PrefixExt) begin
      ext_armed = 1'b1;
    end else if (it.sb[ReleaseBit]) begin
      ext_armed = 1'b0;
    end else begin
      if (!game_on && !ext_armed) begin
        ch = us_char(it.sb[6:0]);
        if (ch != '0) begin
          ring[wr_ptr] = ch;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          if (wr_ptr == 0) n_wraps++;
          r.ch  = ch;
          r.acc = 1'b1;
          n_buffered++;
        end
      end
      ext_armed = 1'b0;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    if (n_errors < 40) $display("[%0t] error: %s", $realtime, msg);
    n_errors++;
  endtask

  // sender: bursts of random length, random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.op        <= OpScan;
      in_if.scan_byte <= '0;
      holding = 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      if (in_if.valid && in_if.ready) begin
        awaited_results.push_back(decode_key('{in_if.op, in_if.scan_byte}));
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (key_queue.size() > 0) begin
          next_key = key_queue.pop_front();
          in_if.valid     <= 1'b1;
          in_if.op        <= next_key.op;
          in_if.scan_byte <= next_key.sb;
          holding = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                   : $urandom_range(0, 3);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each item, stall pattern chosen by bits 9:8 of the cycle count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("result item with nothing expected");
        end else begin
          head_result = awaited_results.pop_front();
          if (out_if.ascii_char !== head_result.ch)
            note_mismatch($sformatf("ascii_char got %h want %h",
                                    out_if.ascii_char, head_result.ch));
          if (out_if.char_accepted !== head_result.acc)
            note_mismatch($sformatf("char_accepted got %b want %b",
                                    out_if.char_accepted, head_result.acc));
          if (out_if.buffer_empty !== head_result.empty)
            note_mismatch($sformatf("buffer_empty got %b want %b",
                                    out_if.buffer_empty, head_result.empty));
        end
      end
      case (cyc[9:8])
        2'd0: out_if.ready <= 1'b1;
        2'd1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_if.ready <= (cyc[2:0] != 3'd0);
        default: out_if.ready <= (cyc[5:3] != 3'b111);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("scancode_to_ascii_fifo: mismatch");
      $finish;
    end
  end

  task automatic set_mode(input logic m);
    @(posedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.game_mode <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    game_on = m;
    n_mode_writes++;
  endtask

  task automatic add_key(input logic op, input scan_t sb);
    key_queue.push_back('{op, sb});
  endtask

  // waits until every key is sent and every result is back, then lets the pipe settle
  task automatic drain();
    while (key_queue.size() != 0 || holding || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // mostly whole keystrokes (optional prefix, make, release), some noise
  task automatic add_random(input int count, input int read_pct);
    int    added;
    scan_t make;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 99) < read_pct) begin
        add_key(OpRead, scan_t'($urandom_range(0, 255)));
        added++;
      end else begin
        case ($urandom_range(0, 9))
          7, 8: begin
            add_key(OpScan, scan_t'($urandom_range(0, 255)));
            added++;
          end
          9: begin
            // broken sequences: doubled prefix or prefix then read, each followed by a release
            add_key(OpScan, PrefixExt);
            if ($urandom_range(0, 1)) add_key(OpScan, PrefixExt);
            else add_key(OpRead, scan_t'($urandom_range(0, 255)));
            add_key(OpScan, scan_t'($urandom_range(128, 255)));
            added += 3;
          end
          default: begin
            if ($urandom_range(0, 4) == 0) begin
              add_key(OpScan, PrefixExt);
              added++;
            end
            make = ($urandom_range(0, 4) == 0) ? scan_t'($urandom_range(0, 127))
                                                : scan_t'($urandom_range(0, 57));
            add_key(OpScan, make);
            added++;
            if ($urandom_range(0, 99) < 85) begin
              add_key(OpScan, make | 8'h80);
              added++;
            end
          end
        endcase
      end
    end
  endtask

  initial begin
    cfg_if.valid     = 1'b0;
    cfg_if.game_mode = 1'b0;
    game_on = 1'b0;
    ext_armed = 1'b0;
    wr_ptr = 0;
    rd_ptr = 0;
    cyc = 0;
    n_errors = 0;
    n_items = 0;
    n_buffered = 0;
    n_readback = 0;
    n_empty = 0;
    n_wraps = 0;
    n_mode_writes = 0;
    wait (rst_ni === 1'b1);

    // terminal mode: empty read, escape/backspace/tab/enter/space, unmapped
    // codes at both ends, prefix handling and release clearing the prefix
    set_mode(1'b0);
    add_key(OpRead, 8'h00);
    add_key(OpScan, 8'h01);
    add_key(OpScan, 8'h0E);
    add_key(OpScan, 8'h0F);
    add_key(OpScan, 8'h1C);
    add_key(OpScan, 8'h39);
    add_key(OpScan, 8'h00);
    add_key(OpScan, 8'h7F);
    add_key(OpScan, PrefixExt);
    add_key(OpScan, 8'h1E);
    add_key(OpScan, 8'h1E);
    add_key(OpScan, PrefixExt);
    add_key(OpScan, 8'hFF);
    add_key(OpScan, 8'h2C);
    add_key(OpScan, PrefixExt);
    add_key(OpScan, PrefixExt);
    add_key(OpScan, 8'h35);
    add_key(OpScan, 8'h37);
    repeat (6) add_key(OpRead, 8'hFF);
    drain();

    // game mode: keys are dropped but waiting characters still read out
    set_mode(1'b1);
    add_key(OpScan, 8'h1E);
    add_key(OpScan, PrefixExt);
    add_key(OpScan, 8'h1E);
    add_key(OpScan, 8'h9E);
    repeat (3) add_key(OpRead, 8'h55);
    add_random(200, 30);
    drain();

    // few reads so the write pointer laps the read pointer
    set_mode(1'b0);
    add_random(600, 4);
    drain();

    set_mode(1'b1);
    add_random(150, 40);
    drain();

    set_mode(1'b0);
    add_random(500, 35);
    drain();

    add_random(350, 60);
    drain();

    $display("run covered %0d items over %0d mode writes: %0d characters buffered,",
             n_items, n_mode_writes, n_buffered);
    $display("  %0d read back, %0d empty reads, %0d ring wraps", n_readback, n_empty,
             n_wraps);
    if (n_errors == 0) begin
      $display("scancode_to_ascii_fifo: match");
    end else begin
      $display("scancode_to_ascii_fifo: mismatch");
    end
    $finish;
  end

endmodule
